### design/lup_pkg.sv
package lup_pkg;

  localparam int UPSAMPLE_FACTOR = 4;
  localparam int LOBES           = 8;
  localparam int SAMPLE_BITS     = 24;
  localparam int COEF_BITS       = 18;

  localparam int TAPS      = 2 * LOBES;
  localparam int SPAN      = LOBES * UPSAMPLE_FACTOR;
  localparam int ROM_DEPTH = TAPS * UPSAMPLE_FACTOR;
  localparam int CFRAC     = COEF_BITS - 2;

  localparam int TAP_W     = $clog2(TAPS);
  localparam int PH_CNT_W  = $clog2(UPSAMPLE_FACTOR);
  localparam int ROM_IDX_W = $clog2(ROM_DEPTH);
  localparam int PHASE_W   = 3;
  localparam int PRIME_W   = $clog2(LOBES + 1);
  localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W     = PROD_W + $clog2(TAPS);

  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam int TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef coef_t [ROM_DEPTH-1:0]         coef_rom_t;

  // one queued item: value to shift in, history clear, and whether it makes a group
  typedef struct packed {
    sample_t val;
    logic    clear;
    logic    emit;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } back_state_t;

  // restoring long division, truncating, used only while building the rom
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(pi*q/d) in q30, d is the factor or the kernel half-span (lobes times factor)
  function automatic longint sin_pi_q30(longint q, bit wide);
    logic        neg;
    logic [63:0] uq;
    logic [63:0] ud;
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    longint      sum;
    neg = (q < 0);
    uq  = neg ? 64'(-q) : 64'(q);
    if (wide) begin
      ud    = 64'(SPAN);
      uq    = uq % (2 * SPAN);
    end else begin
      ud    = 64'(UPSAMPLE_FACTOR);
      uq    = uq % (2 * UPSAMPLE_FACTOR);
    end
    if (uq >= ud) begin
      uq  = uq - ud;
      neg = !neg;
    end
    if (2 * uq > ud) uq = ud - uq;
    if (wide) theta = PI_Q30 * uq / SPAN;
    else      theta = PI_Q30 * uq / UPSAMPLE_FACTOR;
    t2   = (theta * theta) >> 30;
    term = theta;
    sum  = longint'(theta);
    for (int k = 1; k <= 8; k++) begin
      term = udiv64((term * t2) >> 30, 64'(TAYLOR_DIV[k-1]));
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    return neg ? -sum : sum;
  endfunction

  function automatic coef_t lanczos_coef(longint p);
    logic [63:0] ap;
    longint      s1;
    longint      s2;
    logic [63:0] m1;
    logic [63:0] m2;
    logic [63:0] pit1;
    logic [63:0] pit2;
    logic [63:0] u1;
    logic [63:0] u2;
    logic [63:0] mag;
    logic [63:0] cap;
    if (p == 0) return coef_t'(64'd1 << CFRAC);
    ap = (p < 0) ? 64'(-p) : 64'(p);
    if (ap >= 64'(SPAN)) return '0;
    s1   = sin_pi_q30(p, 1'b0);
    s2   = sin_pi_q30(p, 1'b1);
    m1   = (s1 < 0) ? 64'(-s1) : 64'(s1);
    m2   = (s2 < 0) ? 64'(-s2) : 64'(s2);
    pit1 = PI_Q30 * ap / UPSAMPLE_FACTOR;
    pit2 = PI_Q30 * ap / SPAN;
    u1   = udiv64(m1 << 30, pit1);
    u2   = udiv64(m2 << 30, pit2);
    mag  = (u1 * u2 + (64'd1 << (59 - CFRAC))) >> (60 - CFRAC);
    cap  = (64'd1 << (COEF_BITS - 1)) - 64'd1;
    if (mag > cap) mag = cap;
    if ((s1 < 0) != (s2 < 0)) return coef_t'(-longint'(mag));
    return coef_t'(mag);
  endfunction

  function automatic coef_rom_t build_rom();
    coef_rom_t rom;
    longint    p;
    for (int ph = 0; ph < UPSAMPLE_FACTOR; ph++) begin
      for (int j = 0; j < TAPS; j++) begin
        p = longint'(j - LOBES) * UPSAMPLE_FACTOR + ph;
        rom[ph*TAPS + j] = lanczos_coef(p);
      end
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_rom();

endpackage

### design/lup_front.sv
module lup_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lup_pkg::sample_t          sample,
  input  logic                      pad,
  input  logic                      start_req,
  input  logic                      q_full,
  output logic                      push,
  output lup_pkg::job_t             job
);
  import lup_pkg::*;

  logic [PRIME_W-1:0] prime_count;
  logic [PRIME_W-1:0] prime_count_next;
  logic [PRIME_W-1:0] prime_base;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // a start request restarts priming with this item counted
  assign prime_base = start_req ? '0 : prime_count;

  always_comb begin
    job.val   = pad ? '0 : sample;
    job.clear = start_req;
    job.emit  = (prime_base == PRIME_W'(LOBES));
    if (prime_base < PRIME_W'(LOBES)) prime_count_next = prime_base + 1'b1;
    else                              prime_count_next = prime_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_count <= '0;
    end else if (push) begin
      prime_count <= prime_count_next;
    end
  end

  a_emit_primed: assert property (@(posedge clk) disable iff (rst)
    push && job.emit |-> !start_req && prime_count == PRIME_W'(LOBES))
    else $error("group issued before priming finished");

endmodule

### design/lup_queue.sv
module lup_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lup_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output lup_pkg::job_t pop_job,
  output logic          empty
);
  import lup_pkg::*;

  job_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_drop: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count did not follow a read");

endmodule

### design/lup_back.sv
module lup_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  lup_pkg::job_t               job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lup_pkg::sample_t            out_sample,
  output logic [lup_pkg::PHASE_W-1:0] phase,
  output logic                        group_last
);
  import lup_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO =
    ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [ACC_W-1:0] RND_HALF =
    ACC_W'(64'sd1 <<< (CFRAC - 1));

  back_state_t              state;
  back_state_t              state_next;
  sample_t                  hist [TAPS];
  logic [TAP_W-1:0]         tap;
  logic [TAP_W-1:0]         tap_next;
  logic [PH_CNT_W-1:0]      ph;
  logic [PH_CNT_W-1:0]      ph_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic [ROM_IDX_W-1:0]     rom_idx;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [ACC_W-1:0]  shifted;
  sample_t                  sat_val;
  logic                     out_load;
  logic                     last_ph;

  assign rom_idx = ROM_IDX_W'(ph) * ROM_IDX_W'(TAPS) + ROM_IDX_W'(tap);
  assign last_ph = (ph == PH_CNT_W'(UPSAMPLE_FACTOR - 1));

  // round half up, floor shift, then clamp to the sample range
  always_comb begin
    rounded = acc + RND_HALF;
    shifted = rounded >>> CFRAC;
    if (shifted > SAT_HI)      sat_val = sample_t'(SAT_HI);
    else if (shifted < SAT_LO) sat_val = sample_t'(SAT_LO);
    else                       sat_val = sample_t'(shifted);
  end

  always_comb begin
    state_next = state;
    tap_next   = tap;
    ph_next    = ph;
    acc_next   = acc;
    pop        = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (job.emit) begin
            state_next = ST_MAC;
            tap_next   = '0;
            ph_next    = '0;
          end
        end
      end
      ST_MAC: begin
        // prod holds the previous tap, stale at tap zero
        acc_next = (tap == '0) ? '0 : acc + ACC_W'(prod);
        tap_next = tap + 1'b1;
        if (tap == TAP_W'(TAPS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        acc_next   = acc + ACC_W'(prod);
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          if (last_ph) begin
            state_next = ST_IDLE;
          end else begin
            ph_next    = ph + 1'b1;
            tap_next   = '0;
            state_next = ST_MAC;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap       <= '0;
      ph        <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < TAPS; j++) hist[j] <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
      ph    <= ph_next;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (pop) begin
        for (int j = TAPS - 1; j > 0; j--) begin
          hist[j] <= job.clear ? '0 : hist[j-1];
        end
        hist[0] <= job.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc  <= acc_next;
    prod <= hist[tap] * $signed(COEF_ROM[rom_idx]);
    if (out_load) begin
      out_sample <= sat_val;
      phase      <= PHASE_W'(ph);
      group_last <= last_ph;
    end
  end

  a_last_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && group_last |-> phase == PHASE_W'(UPSAMPLE_FACTOR - 1))
    else $error("group end flagged on a middle phase");

  a_phase_restart: assert property (@(posedge clk) disable iff (rst)
    state == ST_MAC && $past(state) != ST_MAC |-> tap == '0)
    else $error("tap count not restarted at phase start");

endmodule

### design/lanczos_integer_upsampler.sv
// channel  dir  handshake           fields
// in       in   in_valid/in_ready   sample[24] s, pad[1], start_req[1]
// out      out  out_valid/out_ready out_sample[24] s, phase[3], group_last[1]
//
// one shared multiply-accumulate takes one tap per cycle: 16 taps, then a drain
// state and an output state per phase, so an item that makes a group of 4 runs
// all its phases in the back end; a priming item only shifts into the history
// reset zeroes the history and priming count at once, no clearing pass
// a 4-deep queue takes input transfers while the back end computes
// a stalled output holds the back end on its finished phase
module lanczos_integer_upsampler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lup_pkg::sample_t            sample,
  input  logic                        pad,
  input  logic                        start_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lup_pkg::sample_t            out_sample,
  output logic [lup_pkg::PHASE_W-1:0] phase,
  output logic                        group_last
);
  import lup_pkg::*;

  job_t push_job;
  job_t pop_job;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  lup_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .pad       (pad),
    .start_req (start_req),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  lup_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  lup_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .job        (pop_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .phase      (phase),
    .group_last (group_last)
  );

endmodule
